// ===== src/assert_macros.svh =====
// assertion macros used by decimal_fixed_point_alu
// no dependencies; bodies are empty when SYNTH is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define DFP_ASSERT_ALWAYS(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed: invariant");
`define DFP_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: implication");
`define DFP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");
`else
`define DFP_ASSERT_ALWAYS(lbl, clk, rst, prop)
`define DFP_ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define DFP_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== src/dfp_pkg.sv =====
// types, commands and scale constants of the decimal fixed-point alu
// no dependencies
package dfp_pkg;

   localparam int DECIMAL_PLACES = 4;
   localparam int DATA_W = 64;
   localparam int HALF_W = DATA_W / 2;
   localparam int NUM_W = 2 * DATA_W;
   localparam int DIV_STAGES = NUM_W;

   // ten to the number of fraction digits
   function automatic logic [DATA_W-1:0] pow10(input int digits);
      logic [DATA_W-1:0] acc;
      acc = 64'd1;
      for (int i = 0; i < digits; i++) begin
         acc = acc * 64'd10;
      end
      return acc;
   endfunction

   localparam logic [DATA_W-1:0] SCALE = pow10(DECIMAL_PLACES);

   typedef enum logic [1:0] {
      CMD_ADD      = 2'd0,
      CMD_MUL      = 2'd1,
      CMD_DIV      = 2'd2,
      CMD_RESERVED = 2'd3
   } cmd_type;

   typedef struct packed {
      logic [1:0]        command;
      logic signed [63:0] operand_a;
      logic signed [63:0] operand_b;
   } req_word_type;

   typedef struct packed {
      logic signed [63:0] value;
      logic               overflow;
      logic               divide_by_zero;
   } rsp_word_type;

   // side information that rides along the pipeline
   typedef struct packed {
      logic [1:0]        cmd;
      logic              neg;
      logic              dz;
      logic [DATA_W-1:0] sum;
      logic              add_ovf;
   } ctl_type;

endpackage

// ===== src/dfp_channels.sv =====
// valid/ready channel interfaces for request and response words
// depends on dfp_pkg
interface dfp_req_if;
   logic                      valid;
   logic                      ready;
   dfp_pkg::req_word_type     data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface dfp_rsp_if;
   logic                      valid;
   logic                      ready;
   dfp_pkg::rsp_word_type     data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== src/decimal_fixed_point_alu.sv =====
// pipeline from request accept to response valid: 1 sign stage, 2 multiply stages,
// 128 restoring-divide stages one quotient bit each, 1 output stage
// throughput: one word per cycle; the whole pipeline advances together and holds
// while the response register is full and not taken
// reset: synchronous, active high, clears every stage valid bit; data regs are not reset
// depends on dfp_pkg, dfp_channels and assert_macros.svh
`include "assert_macros.svh"

module decimal_fixed_point_alu (
   input  logic        clock,
   input  logic        reset,
   dfp_req_if.sink     req_ch,
   dfp_rsp_if.source   rsp_ch
);

   localparam int DW = dfp_pkg::DATA_W;
   localparam int HW = dfp_pkg::HALF_W;
   localparam int NW = dfp_pkg::NUM_W;
   localparam int NS = dfp_pkg::DIV_STAGES;

   logic advance;

   // stage 1: magnitudes, operand selection, add
   logic              vld1_ff;
   dfp_pkg::ctl_type  ctl1_ff, ctl1_in;
   logic [DW-1:0]     ma1_ff, ma1_in, mb1_ff, mb1_in, d1_ff, d1_in;

   // stage 2: partial products
   logic              vld2_ff;
   dfp_pkg::ctl_type  ctl2_ff;
   logic [DW-1:0]     d2_ff;
   logic [DW-1:0]     p00_ff, p01_ff, p10_ff, p11_ff;

   // divider stages; index 0 holds the full product
   logic              vld_ff [0:NS];
   dfp_pkg::ctl_type  ctl_ff [0:NS];
   logic [DW-1:0]     d_ff   [0:NS];
   logic [DW-1:0]     rem_ff [0:NS];
   logic [NW-1:0]     nq_ff  [0:NS];

   // output register
   logic                  rsp_vld_ff;
   dfp_pkg::rsp_word_type rsp_ff, rsp_in;

   assign advance       = !rsp_vld_ff || rsp_ch.ready;
   assign req_ch.ready  = advance;
   assign rsp_ch.valid  = rsp_vld_ff;
   assign rsp_ch.data   = rsp_ff;

   // stage 1 logic
   always_comb begin
      logic [DW-1:0] a, b, mag_a, mag_b, sum;
      a     = req_ch.data.operand_a;
      b     = req_ch.data.operand_b;
      mag_a = a[DW-1] ? (~a + 64'd1) : a;
      mag_b = b[DW-1] ? (~b + 64'd1) : b;
      sum   = a + b;
      ctl1_in.cmd     = req_ch.data.command;
      ctl1_in.neg     = a[DW-1] ^ b[DW-1];
      ctl1_in.dz      = (req_ch.data.command == dfp_pkg::CMD_DIV) && (b == '0);
      ctl1_in.sum     = sum;
      ctl1_in.add_ovf = (a[DW-1] == b[DW-1]) && (sum[DW-1] != a[DW-1]);
      ma1_in = mag_a;
      if (req_ch.data.command == dfp_pkg::CMD_DIV) begin
         mb1_in = dfp_pkg::SCALE;
         d1_in  = mag_b;
      end else begin
         mb1_in = mag_b;
         d1_in  = dfp_pkg::SCALE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
         vld_ff[0] <= 1'b0;
      end else if (advance) begin
         vld1_ff   <= req_ch.valid;
         vld2_ff   <= vld1_ff;
         vld_ff[0] <= vld2_ff;
      end
   end

   // stage 1 to 3 data
   always_ff @(posedge clock) begin
      if (advance) begin
         ctl1_ff <= ctl1_in;
         ma1_ff  <= ma1_in;
         mb1_ff  <= mb1_in;
         d1_ff   <= d1_in;
         ctl2_ff <= ctl1_ff;
         d2_ff   <= d1_ff;
         p00_ff  <= ma1_ff[HW-1:0]  * mb1_ff[HW-1:0];
         p01_ff  <= ma1_ff[HW-1:0]  * mb1_ff[DW-1:HW];
         p10_ff  <= ma1_ff[DW-1:HW] * mb1_ff[HW-1:0];
         p11_ff  <= ma1_ff[DW-1:HW] * mb1_ff[DW-1:HW];
         ctl_ff[0] <= ctl2_ff;
         d_ff[0]   <= d2_ff;
         rem_ff[0] <= '0;
         nq_ff[0]  <= {p11_ff, p00_ff}
                    + {{HW{1'b0}}, p01_ff, {HW{1'b0}}}
                    + {{HW{1'b0}}, p10_ff, {HW{1'b0}}};
      end
   end

   // one restoring-divide step per stage, quotient bits shift in from the bottom
   for (genvar k = 0; k < NS; k++) begin : g_div
      logic [DW:0]   r2;
      logic          ge;
      logic [DW:0]   diff;
      logic [DW-1:0] rem_in;
      logic [NW-1:0] nq_in;

      always_comb begin
         r2     = {rem_ff[k], nq_ff[k][NW-1]};
         diff   = r2 - {1'b0, d_ff[k]};
         ge     = (r2 >= {1'b0, d_ff[k]});
         rem_in = ge ? diff[DW-1:0] : r2[DW-1:0];
         nq_in  = {nq_ff[k][NW-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k+1] <= 1'b0;
         end else if (advance) begin
            vld_ff[k+1] <= vld_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            ctl_ff[k+1] <= ctl_ff[k];
            d_ff[k+1]   <= d_ff[k];
            rem_ff[k+1] <= rem_in;
            nq_ff[k+1]  <= nq_in;
         end
      end
   end

   // sign, overflow check and command select
   always_comb begin
      logic [NW-1:0]     q;
      logic [DW-1:0]     limit;
      dfp_pkg::ctl_type  c;
      q     = nq_ff[NS];
      c     = ctl_ff[NS];
      limit = c.neg ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
      rsp_in = '0;
      unique case (c.cmd)
         dfp_pkg::CMD_ADD: begin
            rsp_in.value    = c.sum;
            rsp_in.overflow = c.add_ovf;
         end
         dfp_pkg::CMD_MUL, dfp_pkg::CMD_DIV: begin
            if (c.dz) begin
               rsp_in.divide_by_zero = 1'b1;
            end else begin
               rsp_in.value    = c.neg ? (~q[DW-1:0] + 64'd1) : q[DW-1:0];
               rsp_in.overflow = (q[NW-1:DW] != '0) || (q[DW-1:0] > limit);
            end
         end
         default: rsp_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (advance) begin
         rsp_vld_ff <= vld_ff[NS];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   `DFP_ASSERT_IMPLY(a_dz_clean, clock, reset, rsp_vld_ff && rsp_ff.divide_by_zero, (rsp_ff.value == '0) && !rsp_ff.overflow)
   `DFP_ASSERT_IMPLY(a_dz_only_div, clock, reset, vld_ff[NS] && ctl_ff[NS].dz, ctl_ff[NS].cmd == dfp_pkg::CMD_DIV)
   `DFP_ASSERT_NEXT(a_hold_on_stall, clock, reset, rsp_vld_ff && !rsp_ch.ready, $stable(vld_ff[NS]) && $stable(vld_ff[0]) && rsp_vld_ff)
   `DFP_ASSERT_IMPLY(a_rem_below_div, clock, reset, vld_ff[NS] && !ctl_ff[NS].dz, rem_ff[NS] < d_ff[NS])

endmodule

// ===== dv/dfp_alu_checker.sv =====
// checker for the decimal fixed-point alu: watches both channels, predicts each
// response word from the request word and compares; depends on dfp_pkg, dfp_channels
module dfp_alu_checker (
   input  logic        clock,
   input  logic        reset,
   dfp_req_if          req_ch,
   dfp_rsp_if          rsp_ch,
   output int          fail_count,
   output int          pending_count
);

   dfp_pkg::rsp_word_type expected_q[$];

   // magnitude of a two's complement word
   function automatic logic [127:0] abs_wide(logic [63:0] x);
      return x[63] ? {64'd0, -x} : {64'd0, x};
   endfunction

   // sign, range check and low 64 bits of a quotient magnitude
   function automatic dfp_pkg::rsp_word_type signed_result(logic [127:0] q, logic neg);
      dfp_pkg::rsp_word_type r;
      logic [127:0] limit;
      limit = neg ? 128'h8000_0000_0000_0000 : 128'h7FFF_FFFF_FFFF_FFFF;
      r.overflow = (q > limit);
      r.value = neg ? -q[63:0] : q[63:0];
      r.divide_by_zero = 1'b0;
      return r;
   endfunction

   // expected response word for one request word
   function automatic dfp_pkg::rsp_word_type alu_result(dfp_pkg::req_word_type w);
      dfp_pkg::rsp_word_type r;
      logic [63:0] a, b, s;
      logic neg;
      a = w.operand_a;
      b = w.operand_b;
      neg = a[63] ^ b[63];
      r = '0;
      case (w.command)
         dfp_pkg::CMD_ADD: begin
            s = a + b;
            r.value = s;
            r.overflow = (a[63] == b[63]) && (s[63] != a[63]);
         end
         dfp_pkg::CMD_MUL:
            r = signed_result((abs_wide(a) * abs_wide(b)) / {64'd0, dfp_pkg::SCALE}, neg);
         dfp_pkg::CMD_DIV: begin
            if (b == 64'd0) r.divide_by_zero = 1'b1;
            else r = signed_result((abs_wide(a) * {64'd0, dfp_pkg::SCALE}) / abs_wide(b),
                                   neg);
         end
         default: r = '0;
      endcase
      return r;
   endfunction

   task automatic report(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      fail_count++;
   endtask

   initial fail_count = 0;
   assign pending_count = expected_q.size();

   // predict on request, compare on response
   always @(posedge clock) begin
      dfp_pkg::rsp_word_type got, want;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) expected_q.push_back(alu_result(req_ch.data));
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = rsp_ch.data;
            if (expected_q.size() == 0) report("response word with none expected");
            else begin
               want = expected_q.pop_front();
               if (got.value !== want.value)
                  report($sformatf("value %h expected %h", got.value, want.value));
               if (got.overflow !== want.overflow)
                  report($sformatf("overflow %b expected %b", got.overflow, want.overflow));
               if (got.divide_by_zero !== want.divide_by_zero)
                  report($sformatf("divide_by_zero %b expected %b",
                                   got.divide_by_zero, want.divide_by_zero));
            end
         end
      end
   end
endmodule

// ===== dv/tb.sv =====
// testbench top for decimal_fixed_point_alu: drives request words with random gaps,
// stalls the response side and gives the verdict; depends on dfp_pkg, dfp_channels, the alu, checker
module tb;

   localparam int LATENCY = 132;
   localparam int WATCHDOG_LIMIT = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count, pending_count;
   int   idle_cycles;
   logic calm;

   dfp_req_if req_ch ();
   dfp_rsp_if rsp_ch ();

   decimal_fixed_point_alu dut (.clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch));
   dfp_alu_checker checker_inst (.clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch),
                                 .fail_count(fail_count), .pending_count(pending_count));

   always #5 clock = ~clock;

   // random operand with bias toward edges and small scaled values
   function automatic logic [63:0] pick_operand();
      case ($urandom_range(0, 5))
         0: return {$urandom, $urandom};
         1: return 64'(signed'($urandom_range(0, 2000000)) - 1000000);
         2: return {{32{1'b0}}, $urandom} << $urandom_range(0, 31);
         3: return -({{32{1'b0}}, $urandom} << $urandom_range(0, 31));
         4: begin
            case ($urandom_range(0, 4))
               0: return 64'h8000_0000_0000_0000;
               1: return 64'h7FFF_FFFF_FFFF_FFFF;
               2: return 64'd0;
               3: return dfp_pkg::SCALE;
               default: return -dfp_pkg::SCALE;
            endcase
         end
         default: return 64'(signed'($urandom_range(0, 200))) * dfp_pkg::SCALE;
      endcase
   endfunction

   // send one request word, idling now and then
   task automatic send_word(logic [1:0] cmd, logic [63:0] a, logic [63:0] b);
      while (!calm && $urandom_range(0, 99) < 30) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data <= '{command: cmd, operand_a: a, operand_b: b};
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   task automatic send_random();
      logic [1:0] cmd;
      cmd = 2'($urandom_range(0, 3));
      send_word(cmd, pick_operand(), ($urandom_range(0, 19) == 0) ? 64'd0 : pick_operand());
   endtask

   // response side stalls
   always @(posedge clock) begin
      rsp_ch.ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 30);
   end

   // watchdog on cycles with no accepted word
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCHDOG_LIMIT) begin
         $display("decimal_fixed_point_alu verification failed");
         $finish;
      end
   end

   initial begin
      logic [63:0] edge_vals[5];
      edge_vals = '{64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF, 64'd0, dfp_pkg::SCALE,
                    64'hFFFF_FFFF_FFFF_FFFF};
      calm = 1'b0;
      req_ch.valid = 1'b0;
      req_ch.data = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: edges for every command, zero divisor, unused command
      foreach (edge_vals[i]) begin
         send_word(dfp_pkg::CMD_ADD, edge_vals[i], edge_vals[(i + 1) % 5]);
         send_word(dfp_pkg::CMD_MUL, edge_vals[i], edge_vals[i]);
         send_word(dfp_pkg::CMD_DIV, edge_vals[i], edge_vals[(i + 4) % 5]);
      end
      send_word(dfp_pkg::CMD_DIV, 64'h7FFF_FFFF_FFFF_FFFF, 64'd0);
      send_word(dfp_pkg::CMD_DIV, 64'h8000_0000_0000_0000, 64'd1);
      send_word(dfp_pkg::CMD_MUL, -dfp_pkg::SCALE, 64'h8000_0000_0000_0000);
      send_word(dfp_pkg::CMD_ADD, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000);
      send_word(dfp_pkg::CMD_RESERVED, 64'h1234, 64'h5678);

      // hold off until the pipeline drains
      req_ch.valid <= 1'b0;
      while (pending_count != 0) @(posedge clock);

      // random, with a stretch of no idling in the middle
      for (int n = 0; n < 1900; n++) begin
         calm = (n >= 800 && n < 1100);
         send_random();
      end
      calm = 1'b0;
      req_ch.valid <= 1'b0;

      while (pending_count != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      if (fail_count == 0) $display("decimal_fixed_point_alu verification clean");
      else $display("decimal_fixed_point_alu verification failed");
      $finish;
   end
endmodule
